FILE: design/event_trace_ring_with_gap_records_macros.svh
// ----------------------------------------------------------------------------
// event_trace_ring_with_gap_records_macros.svh
// Assertion helpers shared by the trace ring RTL.
// ----------------------------------------------------------------------------
`ifndef EVENT_TRACE_RING_WITH_GAP_RECORDS_MACROS_SVH
`define EVENT_TRACE_RING_WITH_GAP_RECORDS_MACROS_SVH

// Property checked on every rising clock edge, masked while reset is high.
`define ETRG_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true.
`define ETRG_NEVER(label, clk, rst, expr, msg) \
   `ETRG_CHECK(label, clk, rst, !(expr), msg)

`endif

FILE: design/etrg_pkg.sv
// ----------------------------------------------------------------------------
// etrg_pkg
// Widths, codes and shared types of the trace ring.
// ----------------------------------------------------------------------------
package etrg_pkg;

   localparam int DEPTH    = 1024;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   localparam int HANDLE_W = 20;
   localparam int LINK_W   = 10;
   localparam int MISSED_W = 32;
   localparam int TIME_W   = 64;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 11;

   localparam logic [MISSED_W-1:0] MISSED_MAX = '1;

   typedef enum logic {
      OP_LOG = 1'b0,
      OP_POP = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_LOGGED   = 3'd0,
      ST_GAP_NEW  = 3'd1,
      ST_GAP_MORE = 3'd2,
      ST_POPPED   = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   // Record store access for one transfer
   typedef struct packed {
      logic                handle_we;
      logic                link_we;
      logic                dir_we;
      logic                time_we;
      logic [IDX_W-1:0]    wr_addr;
      logic [HANDLE_W-1:0] wr_handle;
      logic [MISSED_W-1:0] wr_link_or_missed;
      logic                wr_dir;
      logic [TIME_W-1:0]   wr_time;
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
   } mem_req_type;

   // Result fields settled at accept time
   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] release_handle;
      logic                rec_valid;
      logic [OCC_W-1:0]    occupancy;
   } issue_type;

endpackage

FILE: design/event_trace_ring_with_gap_records.sv
// ----------------------------------------------------------------------------
// event_trace_ring_with_gap_records
// Circular trace buffer of packet events; failed or refused captures
// collapse into gap records that count the events missed.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------
//  req_    | in        | req_valid/req_stall| operation, handle, link, dir, time
//  rsp_    | out       | rsp_valid/rsp_stall| status, release, popped record, occ
//
//  One transfer per clock in each direction while no stall holds it; a result
//  reaches rsp_ through the read stage and store read, which load at the
//  transfer edge, and then the result register, which a stall on rsp_ holds.
//  The rate is set by the single write and single read port of the record
//  stores: each request does at most one write and one read.
//  Reset clears pointers, count and pipeline valids; store contents are not
//  cleared and need no clearing pass (only occupied entries are read).
//  A stall on rsp_ backs up through the read stage to req_stall.
//
`include "event_trace_ring_with_gap_records_macros.svh"

module event_trace_ring_with_gap_records (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [etrg_pkg::HANDLE_W-1:0] req_packet_handle,
   input  logic [etrg_pkg::LINK_W-1:0]   req_link_number,
   input  logic                          req_send_flag,
   input  logic [etrg_pkg::TIME_W-1:0]   req_event_time,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [etrg_pkg::STATUS_W-1:0] rsp_status,
   output logic [etrg_pkg::HANDLE_W-1:0] rsp_release_handle,
   output logic                          rsp_rec_is_gap,
   output logic [etrg_pkg::HANDLE_W-1:0] rsp_rec_handle,
   output logic [etrg_pkg::MISSED_W-1:0] rsp_rec_link_or_missed,
   output logic                          rsp_rec_send_flag,
   output logic [etrg_pkg::TIME_W-1:0]   rsp_rec_time,
   output logic [etrg_pkg::OCC_W-1:0]    rsp_occupancy
);
   import etrg_pkg::*;

   logic                accept;
   mem_req_type         mem_req;
   issue_type           issue;

   // registered read data of the four record stores
   logic [HANDLE_W-1:0] rd_handle;
   logic [MISSED_W-1:0] rd_link_or_missed;
   logic                rd_dir;
   logic [TIME_W-1:0]   rd_time;

   // Pointer/count logic: decides the whole outcome at transfer time and
   // issues the store write (log or gap) or the oldest-record read (pop).
   etrg_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_operation     (req_operation),
      .req_packet_handle (req_packet_handle),
      .req_link_number   (req_link_number),
      .req_send_flag     (req_send_flag),
      .req_event_time    (req_event_time),
      .mem_req           (mem_req),
      .issue             (issue)
   );

   // Record stores, split by field so a gap extension writes only the count
   // and a new gap keeps the slot's direction bit.
   etrg_ram #(.WIDTH(HANDLE_W), .DEPTH(DEPTH)) u_handle_ram (
      .clock   (clock),
      .wr_en   (mem_req.handle_we),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_handle),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_handle)
   );

   etrg_ram #(.WIDTH(MISSED_W), .DEPTH(DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_req.link_we),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_link_or_missed),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_link_or_missed)
   );

   etrg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_dir_ram (
      .clock   (clock),
      .wr_en   (mem_req.dir_we),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_dir),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_dir)
   );

   etrg_ram #(.WIDTH(TIME_W), .DEPTH(DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (mem_req.time_we),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_time),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_time)
   );

   // Read stage plus result register. Store reads only happen on a request
   // transfer, so read data holds while the read stage is stalled.
   etrg_resp u_resp (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .accept                 (accept),
      .issue                  (issue),
      .rd_handle              (rd_handle),
      .rd_link_or_missed      (rd_link_or_missed),
      .rd_dir                 (rd_dir),
      .rd_time                (rd_time),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_release_handle     (rsp_release_handle),
      .rsp_rec_is_gap         (rsp_rec_is_gap),
      .rsp_rec_handle         (rsp_rec_handle),
      .rsp_rec_link_or_missed (rsp_rec_link_or_missed),
      .rsp_rec_send_flag      (rsp_rec_send_flag),
      .rsp_rec_time           (rsp_rec_time),
      .rsp_occupancy          (rsp_occupancy)
   );

   // a popped gap never reports a direction or a handle
   `ETRG_CHECK(a_gap_fields, clock, reset, (rsp_valid && rsp_rec_is_gap) |-> (!rsp_rec_send_flag && rsp_rec_handle == '0), "gap record with packet fields")
   // a release only ever comes with a gap outcome
   `ETRG_CHECK(a_release_gap, clock, reset, (rsp_valid && rsp_release_handle != '0) |-> (rsp_status == ST_GAP_NEW || rsp_status == ST_GAP_MORE), "release without gap")
   // reported occupancy never exceeds the ring depth
   `ETRG_NEVER(a_occ_bound, clock, reset, rsp_valid && (rsp_occupancy > OCC_W'(DEPTH)), "occupancy above depth")

endmodule

FILE: design/etrg_ram.sv
// ----------------------------------------------------------------------------
// etrg_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module etrg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/etrg_ctrl.sv
// ----------------------------------------------------------------------------
// etrg_ctrl
// Ring pointers, record count, gap tracking and record store access.
// ----------------------------------------------------------------------------
`include "event_trace_ring_with_gap_records_macros.svh"

module etrg_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_operation,
   input  logic [etrg_pkg::HANDLE_W-1:0] req_packet_handle,
   input  logic [etrg_pkg::LINK_W-1:0]   req_link_number,
   input  logic                          req_send_flag,
   input  logic [etrg_pkg::TIME_W-1:0]   req_event_time,
   output etrg_pkg::mem_req_type         mem_req,
   output etrg_pkg::issue_type           issue
);
   import etrg_pkg::*;

   logic [IDX_W-1:0]    oldest_ff, oldest_in;
   logic [IDX_W-1:0]    newest_ff, newest_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                gap_ff, gap_in;
   // missed count of the newest record, valid while it is a gap
   logic [MISSED_W-1:0] missed_ff, missed_in;

   logic                full;
   logic                no_handle;
   logic [IDX_W-1:0]    next_newest;
   logic [IDX_W-1:0]    next_oldest;

   assign full        = (count_ff == CNT_W'(DEPTH));
   assign no_handle   = (req_packet_handle == '0);
   assign next_newest = (newest_ff == IDX_W'(DEPTH - 1)) ? '0 : newest_ff + 1'b1;
   assign next_oldest = (oldest_ff == IDX_W'(DEPTH - 1)) ? '0 : oldest_ff + 1'b1;

   always_comb begin
      oldest_in = oldest_ff;
      newest_in = newest_ff;
      count_in  = count_ff;
      gap_in    = gap_ff;
      missed_in = missed_ff;
      mem_req   = '0;
      issue     = '0;
      mem_req.wr_addr = newest_ff;
      mem_req.rd_addr = oldest_ff;
      mem_req.wr_time = req_event_time;
      mem_req.wr_dir  = req_send_flag;

      if (accept) begin
         unique case (op_type'(req_operation))
            OP_LOG: begin
               if (no_handle || full) begin
                  if (full && !no_handle) begin
                     issue.release_handle = req_packet_handle;
                  end
                  if (count_ff != '0 && gap_ff) begin
                     missed_in = (missed_ff == MISSED_MAX) ? missed_ff
                                                            : missed_ff + 1'b1;
                     mem_req.link_we           = 1'b1;
                     mem_req.wr_link_or_missed = missed_in;
                     issue.status              = ST_GAP_MORE;
                  end else begin
                     // newest slot becomes a gap; direction bit is left alone
                     missed_in                 = MISSED_W'(1);
                     mem_req.handle_we         = 1'b1;
                     mem_req.link_we           = 1'b1;
                     mem_req.time_we           = 1'b1;
                     mem_req.wr_handle         = '0;
                     mem_req.wr_link_or_missed = missed_in;
                     if (count_ff == '0) begin
                        count_in = CNT_W'(1);
                     end
                     gap_in       = 1'b1;
                     issue.status = ST_GAP_NEW;
                  end
               end else begin
                  if (count_ff != '0) begin
                     newest_in = next_newest;
                  end
                  count_in                  = count_ff + 1'b1;
                  mem_req.wr_addr           = newest_in;
                  mem_req.handle_we         = 1'b1;
                  mem_req.link_we           = 1'b1;
                  mem_req.dir_we            = 1'b1;
                  mem_req.time_we           = 1'b1;
                  mem_req.wr_handle         = req_packet_handle;
                  mem_req.wr_link_or_missed = MISSED_W'(req_link_number);
                  gap_in                    = 1'b0;
                  issue.status              = ST_LOGGED;
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  issue.status = ST_EMPTY;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  issue.rec_valid = 1'b1;
                  count_in        = count_ff - 1'b1;
                  if (count_ff != CNT_W'(1)) begin
                     oldest_in = next_oldest;
                  end else begin
                     gap_in = 1'b0;
                  end
                  issue.status = ST_POPPED;
               end
            end
            default: begin
               issue.status = ST_EMPTY;
            end
         endcase
         issue.occupancy = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         newest_ff <= '0;
         count_ff  <= '0;
         gap_ff    <= 1'b0;
      end else begin
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         count_ff  <= count_in;
         gap_ff    <= gap_in;
      end
      missed_ff <= missed_in;
   end

   `ETRG_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(DEPTH), "record count above depth")
   `ETRG_CHECK(a_gap_needs_record, clock, reset, gap_ff |-> (count_ff != '0), "gap flag on empty ring")
   `ETRG_CHECK(a_idle_holds, clock, reset, !accept |=> ($stable(count_ff) && $stable(newest_ff) && $stable(oldest_ff)), "ring state moved without a transfer")

endmodule

FILE: design/etrg_resp.sv
// ----------------------------------------------------------------------------
// etrg_resp
// Read-data stage and result register with input flow control.
// ----------------------------------------------------------------------------
module etrg_resp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          accept,
   input  etrg_pkg::issue_type           issue,
   input  logic [etrg_pkg::HANDLE_W-1:0] rd_handle,
   input  logic [etrg_pkg::MISSED_W-1:0] rd_link_or_missed,
   input  logic                          rd_dir,
   input  logic [etrg_pkg::TIME_W-1:0]   rd_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [etrg_pkg::STATUS_W-1:0] rsp_status,
   output logic [etrg_pkg::HANDLE_W-1:0] rsp_release_handle,
   output logic                          rsp_rec_is_gap,
   output logic [etrg_pkg::HANDLE_W-1:0] rsp_rec_handle,
   output logic [etrg_pkg::MISSED_W-1:0] rsp_rec_link_or_missed,
   output logic                          rsp_rec_send_flag,
   output logic [etrg_pkg::TIME_W-1:0]   rsp_rec_time,
   output logic [etrg_pkg::OCC_W-1:0]    rsp_occupancy
);
   import etrg_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   issue_type           s1_issue_ff, s1_issue_in;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [HANDLE_W-1:0] release_ff, release_in;
   logic                is_gap_ff, is_gap_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [MISSED_W-1:0] lm_ff, lm_in;
   logic                dir_ff, dir_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;

   logic                s1_move;
   logic                rec_gap;

   assign s1_move   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;
   assign rec_gap   = (rd_handle == '0);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_issue_in  = s1_issue_ff;
      out_valid_in = out_valid_ff;
      status_in    = status_ff;
      release_in   = release_ff;
      is_gap_in    = is_gap_ff;
      handle_in    = handle_ff;
      lm_in        = lm_ff;
      dir_in       = dir_ff;
      time_in      = time_ff;
      occ_in       = occ_ff;

      if (s1_move) begin
         out_valid_in = s1_valid_ff;
         status_in    = s1_issue_ff.status;
         release_in   = s1_issue_ff.release_handle;
         occ_in       = s1_issue_ff.occupancy;
         if (s1_issue_ff.rec_valid) begin
            is_gap_in = rec_gap;
            handle_in = rd_handle;
            lm_in     = rd_link_or_missed;
            dir_in    = rec_gap ? 1'b0 : rd_dir;
            time_in   = rd_time;
         end else begin
            is_gap_in = 1'b0;
            handle_in = '0;
            lm_in     = '0;
            dir_in    = 1'b0;
            time_in   = '0;
         end
      end

      if (s1_move || !s1_valid_ff) begin
         s1_valid_in = accept;
         s1_issue_in = issue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_issue_ff <= s1_issue_in;
      status_ff   <= status_in;
      release_ff  <= release_in;
      is_gap_ff   <= is_gap_in;
      handle_ff   <= handle_in;
      lm_ff       <= lm_in;
      dir_ff      <= dir_in;
      time_ff     <= time_in;
      occ_ff      <= occ_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_status             = status_ff;
   assign rsp_release_handle     = release_ff;
   assign rsp_rec_is_gap         = is_gap_ff;
   assign rsp_rec_handle         = handle_ff;
   assign rsp_rec_link_or_missed = lm_ff;
   assign rsp_rec_send_flag      = dir_ff;
   assign rsp_rec_time           = time_ff;
   assign rsp_occupancy          = occ_ff;

endmodule

FILE: verif/trace_ring_check_pkg.sv
// ----------------------------------------------------------------------------
// trace_ring_check_pkg
// Expected-result tracking for the trace ring testbench: a shadow of the
// record ring that predicts each response, plus the field-by-field check.
// ----------------------------------------------------------------------------
package trace_ring_check_pkg;

   import etrg_pkg::*;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] release_handle;
      logic                rec_is_gap;
      logic [HANDLE_W-1:0] rec_handle;
      logic [MISSED_W-1:0] rec_link_or_missed;
      logic                rec_send_flag;
      logic [TIME_W-1:0]   rec_time;
      logic [OCC_W-1:0]    occupancy;
   } trace_result_type;

   class trace_ring_scoreboard;

      // shadow ring; handle 0 in a slot marks a gap record
      logic [HANDLE_W-1:0] slot_handle [DEPTH];
      logic [MISSED_W-1:0] slot_link_or_missed [DEPTH];
      logic                slot_dir [DEPTH];
      logic [TIME_W-1:0]   slot_time [DEPTH];
      int unsigned         head;
      int unsigned         tail;
      int unsigned         held;
      bit                  tail_is_gap;

      trace_result_type    expected_results [$];

      int unsigned         errors;
      int unsigned         checked;
      int unsigned         requests;
      int unsigned         status_count [5];
      int unsigned         released;
      int unsigned         peak_held;

      function new();
         head        = 0;
         tail        = 0;
         held        = 0;
         tail_is_gap = 1'b0;
         errors      = 0;
         checked     = 0;
         requests    = 0;
         released    = 0;
         peak_held   = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function int unsigned ring_step(int unsigned idx);
         return (idx == DEPTH - 1) ? 0 : idx + 1;
      endfunction

      // Update the shadow ring for one accepted request and queue its result.
      function void note_request(op_type op, logic [HANDLE_W-1:0] handle,
                                 logic [LINK_W-1:0] link, logic dir,
                                 logic [TIME_W-1:0] stamp);
         trace_result_type want;
         bit               full;
         want = '0;
         requests++;
         if (op == OP_LOG) begin
            full = (held >= DEPTH);
            if (handle == '0 || full) begin
               if (full && handle != '0) begin
                  want.release_handle = handle;
                  released++;
               end
               if (held != 0 && tail_is_gap) begin
                  if (slot_link_or_missed[tail] != MISSED_MAX)
                     slot_link_or_missed[tail] = slot_link_or_missed[tail] + 1'b1;
                  want.status = ST_GAP_MORE;
               end else begin
                  // overwrite newest slot; direction bit left as it was
                  slot_handle[tail]         = '0;
                  slot_link_or_missed[tail] = 1;
                  slot_time[tail]           = stamp;
                  if (held == 0) held = 1;
                  tail_is_gap = 1'b1;
                  want.status = ST_GAP_NEW;
               end
            end else begin
               if (held != 0) tail = ring_step(tail);
               held++;
               slot_handle[tail]         = handle;
               slot_link_or_missed[tail] = {{(MISSED_W-LINK_W){1'b0}}, link};
               slot_dir[tail]            = dir;
               slot_time[tail]           = stamp;
               tail_is_gap = 1'b0;
               want.status = ST_LOGGED;
            end
         end else if (held == 0) begin
            want.status = ST_EMPTY;
         end else begin
            want.rec_handle         = slot_handle[head];
            want.rec_is_gap         = (slot_handle[head] == '0);
            want.rec_link_or_missed = slot_link_or_missed[head];
            want.rec_send_flag      = want.rec_is_gap ? 1'b0 : slot_dir[head];
            want.rec_time           = slot_time[head];
            held--;
            if (held != 0) head = ring_step(head);
            else tail_is_gap = 1'b0;
            want.status = ST_POPPED;
         end
         want.occupancy = held[OCC_W-1:0];
         if (held > peak_held) peak_held = held;
         status_count[want.status]++;
         expected_results.push_back(want);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                  checked, what, got, want);
      endtask

      task check_result(trace_result_type got);
         trace_result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("result with none pending, status", 64'(got.status), '0);
            return;
         end
         want = expected_results.pop_front();
         if (got.status !== want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
         if (got.release_handle !== want.release_handle)
            report_mismatch("release_handle", 64'(got.release_handle),
                            64'(want.release_handle));
         if (got.rec_is_gap !== want.rec_is_gap)
            report_mismatch("rec_is_gap", 64'(got.rec_is_gap), 64'(want.rec_is_gap));
         if (got.rec_handle !== want.rec_handle)
            report_mismatch("rec_handle", 64'(got.rec_handle), 64'(want.rec_handle));
         if (got.rec_link_or_missed !== want.rec_link_or_missed)
            report_mismatch("rec_link_or_missed", 64'(got.rec_link_or_missed),
                            64'(want.rec_link_or_missed));
         if (got.rec_send_flag !== want.rec_send_flag)
            report_mismatch("rec_send_flag", 64'(got.rec_send_flag),
                            64'(want.rec_send_flag));
         if (got.rec_time !== want.rec_time)
            report_mismatch("rec_time", got.rec_time, want.rec_time);
         if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
         checked++;
      endtask

   endclass

endpackage

FILE: verif/event_trace_ring_with_gap_records_test.sv
// ----------------------------------------------------------------------------
// event_trace_ring_with_gap_records_test
// Drives log and pop requests into the trace ring with random idle gaps on
// both channels, predicts every response with a shadow ring and checks it.
// ----------------------------------------------------------------------------
module event_trace_ring_with_gap_records_test;

   import etrg_pkg::*;
   import trace_ring_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES    = 8;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_operation = 1'b0;
   logic [HANDLE_W-1:0] req_packet_handle = '0;
   logic [LINK_W-1:0]   req_link_number = '0;
   logic                req_send_flag = 1'b0;
   logic [TIME_W-1:0]   req_event_time = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [HANDLE_W-1:0] rsp_release_handle;
   logic                rsp_rec_is_gap;
   logic [HANDLE_W-1:0] rsp_rec_handle;
   logic [MISSED_W-1:0] rsp_rec_link_or_missed;
   logic                rsp_rec_send_flag;
   logic [TIME_W-1:0]   rsp_rec_time;
   logic [OCC_W-1:0]    rsp_occupancy;

   trace_ring_scoreboard sb;

   // Burst flags switch idling off for stretches on each side.
   bit          sender_burst = 1'b0;
   bit          rsp_burst    = 1'b0;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   bit          rsp_hold_req = 1'b0;
   int unsigned cycle_count  = 0;

   always #2 clock = ~clock;

   event_trace_ring_with_gap_records u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_operation          (req_operation),
      .req_packet_handle      (req_packet_handle),
      .req_link_number        (req_link_number),
      .req_send_flag          (req_send_flag),
      .req_event_time         (req_event_time),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_release_handle     (rsp_release_handle),
      .rsp_rec_is_gap         (rsp_rec_is_gap),
      .rsp_rec_handle         (rsp_rec_handle),
      .rsp_rec_link_or_missed (rsp_rec_link_or_missed),
      .rsp_rec_send_flag      (rsp_rec_send_flag),
      .rsp_rec_time           (rsp_rec_time),
      .rsp_occupancy          (rsp_occupancy)
   );

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still pending",
                  cycle_count, sb.expected_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // One request transfer. Payload changes only at the falling edge; valid is
   // lowered during the idle gap and otherwise stays high straight into the
   // next transfer, so it is never dropped and raised in the same step.
   task automatic send_req(op_type op, logic [HANDLE_W-1:0] handle,
                           logic [LINK_W-1:0] link, logic dir,
                           logic [TIME_W-1:0] stamp);
      int unsigned gap;
      gap = sender_burst ? 0 : $urandom_range(0, 11);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_packet_handle <= handle;
      req_link_number   <= link;
      req_send_flag     <= dir;
      req_event_time    <= stamp;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, handle, link, dir, stamp);
   endtask

   // Random request. Pops still carry random payload bits, which the block
   // must ignore; zero_pct sets how often a log brings a failed copy.
   task automatic random_item(int unsigned pop_pct, int unsigned zero_pct);
      logic [31:0]         a;
      logic [31:0]         b;
      logic [31:0]         c;
      logic [HANDLE_W-1:0] handle;
      a = $urandom();
      b = $urandom();
      c = $urandom();
      if ($urandom_range(0, 39) == 0) sender_burst = ~sender_burst;
      handle = a[HANDLE_W-1:0];
      if ($urandom_range(0, 99) < zero_pct) handle = '0;
      else if (handle == '0) handle = 20'd1;
      if ($urandom_range(0, 99) < pop_pct)
         send_req(OP_POP, handle, a[29:20], a[30], {b, c});
      else
         send_req(OP_LOG, handle, a[29:20], a[30], {b, c});
   endtask

   // Sender pause: valid drops and nothing is offered until every queued
   // response has come back.
   task automatic wait_all_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
   endtask

   // Response side: a random number of stall cycles before each transfer,
   // or the long hold-off when asked for, then stall low until a response
   // is taken. Outputs are sampled at the rising edge of the transfer.
   initial begin : response_side
      int unsigned      stall_len;
      trace_result_type got;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 29) == 0) rsp_burst = ~rsp_burst;
         stall_len = rsp_burst ? 0 : $urandom_range(0, 11);
         if (rsp_hold_req) begin
            stall_len    = RSP_HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end
         repeat (stall_len) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.status             = status_type'(rsp_status);
         got.release_handle     = rsp_release_handle;
         got.rec_is_gap         = rsp_rec_is_gap;
         got.rec_handle         = rsp_rec_handle;
         got.rec_link_or_missed = rsp_rec_link_or_missed;
         got.rec_send_flag      = rsp_rec_send_flag;
         got.rec_time           = rsp_rec_time;
         got.occupancy          = rsp_occupancy;
         sb.check_result(got);
      end
   end

   initial begin : stimulus
      int unsigned i;
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed corner cases ----
      // pop from an empty ring
      send_req(OP_POP, 20'hFFFFF, 10'h3FF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      // failed copy on an empty ring starts a gap that becomes the only record
      send_req(OP_LOG, 20'h0, 10'h3FF, 1'b1, 64'h0);
      send_req(OP_LOG, 20'h0, 10'h000, 1'b0, 64'h1);            // gap extended
      send_req(OP_LOG, 20'hFFFFF, 10'h3FF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(OP_LOG, 20'h00001, 10'h000, 1'b1, 64'h0);
      // failed copy over a packet record: it turns into a gap, keeps dir bit
      send_req(OP_LOG, 20'h0, 10'h155, 1'b0, 64'h8000_0000_0000_0000);
      send_req(OP_LOG, 20'h0, 10'h2AA, 1'b1, 64'h5555_5555_5555_5555);
      send_req(OP_LOG, 20'h5A5A5, 10'h155, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
      send_req(OP_LOG, 20'hA5A5A, 10'h2AA, 1'b0, 64'h0000_0000_FFFF_FFFF);
      // pops: gap, packet, converted gap (direction reads as 0), packets
      repeat (5) send_req(OP_POP, 20'h0, 10'h0, 1'b0, 64'h0);
      send_req(OP_POP, 20'h0, 10'h0, 1'b0, 64'h0);               // empty again
      // gap as the last record: popping it clears the gap state, so the
      // next failed copy starts a fresh gap instead of extending
      send_req(OP_LOG, 20'h0, 10'h001, 1'b0, 64'h7);
      send_req(OP_POP, 20'h12345, 10'h3FF, 1'b1, 64'h0);
      send_req(OP_LOG, 20'h0, 10'h002, 1'b1, 64'h8);
      send_req(OP_LOG, 20'h80000, 10'h200, 1'b0, 64'h8000_0000_0000_0001);
      send_req(OP_POP, 20'h0, 10'h0, 1'b0, 64'h0);
      send_req(OP_POP, 20'h0, 10'h0, 1'b0, 64'h0);               // last record
      send_req(OP_LOG, 20'h00002, 10'h001, 1'b1, 64'h10);        // same slot
      send_req(OP_POP, 20'h0, 10'h0, 1'b0, 64'h0);
      wait_all_responses();

      // ---- mixed traffic at low occupancy ----
      // Partway in, the receiver holds off for a long stretch while requests
      // keep coming, so the pipeline backs up onto req_stall.
      for (i = 0; i < 60; i++) begin
         if (i == 20) begin
            rsp_hold_req = 1'b1;
            sender_burst = 1'b1;
         end
         random_item(35, 12);
      end
      wait_all_responses();

      // ---- fill to capacity; the newest index wraps on the way ----
      while (sb.held < DEPTH) random_item(1, 1);

      // ---- full ring: refused handles come back, gaps start and grow,
      //      occasional pops make room for a record or two ----
      for (i = 0; i < 60; i++) begin
         if (i == 15) rsp_hold_req = 1'b1;
         random_item(20, 25);
      end
      wait_all_responses();

      // ---- a short run of mostly pops off the nearly full ring ----
      repeat (20) random_item(92, 10);

      // Missed-count saturation needs 2^32 missed events and is out of reach
      // in a run of this length.
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests, %0d responses checked: %0d logged, %0d gaps new,",
               sb.requests, sb.checked, sb.status_count[ST_LOGGED],
               sb.status_count[ST_GAP_NEW]);
      $display("%0d gaps extended, %0d pops, %0d empty pops, %0d handles refused, peak %0d",
               sb.status_count[ST_GAP_MORE], sb.status_count[ST_POPPED],
               sb.status_count[ST_EMPTY], sb.released, sb.peak_held);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/etrg_pkg.sv
design/etrg_ram.sv
design/etrg_ctrl.sv
design/etrg_resp.sv
design/event_trace_ring_with_gap_records.sv
verif/trace_ring_check_pkg.sv
verif/event_trace_ring_with_gap_records_test.sv
